@@ src/fdo_pkg.sv @@
// Shared types and constants of the Fermi-Dirac occupancy evaluator.
// No dependencies; imported by fdo_rom and fermi_dirac_occupancy.
package fdo_pkg;

   // Q4.12 signed energy, Q8.8 unsigned reciprocal kT, Q1.15 occupancy
   typedef logic signed [15:0] q4_12_type;
   typedef logic [15:0]        recip_type;
   typedef logic [15:0]        occ_type;
   typedef logic [0:0]         csr_index_type;
   typedef logic [15:0]        csr_data_type;

   // register indexes
   localparam csr_index_type CSR_FERMI_LEVEL = 1'd0;
   localparam csr_index_type CSR_INV_KT      = 1'd1;

   // register reset values
   localparam q4_12_type FERMI_LEVEL_RESET = 16'sd2253;
   localparam recip_type INV_KT_RESET      = 16'd9882;

   // occupancy of one in Q1.15
   localparam occ_type OCC_ONE = 16'd32768;

   // Q.20 product bits at and above this position mean |x| >= 16
   localparam int SAT_BIT = 24;

endpackage

@@ src/fdo_rom.sv @@
// Occupancy table f(t) = 1/(1+exp(t)) over [0,16], Q1.15, built at elaboration.
// Two registered reads per cycle while en is high (entry idx and idx+1). Depends on fdo_pkg.
module fdo_rom #(
   parameter int ENTRIES = 256,
   parameter int IDX_W   = $clog2(ENTRIES)
) (
   input  logic               clock,
   input  logic               en,
   input  logic [IDX_W-1:0]   rd_idx,
   output fdo_pkg::occ_type   rd_lo_ff,
   output fdo_pkg::occ_type   rd_hi_ff
);
   import fdo_pkg::*;

   // unsigned long division, one quotient bit per step, table build only
   function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 64'd0;
      rem = 64'd0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // exp(-t) by series and five squarings, then f = y/(1+y) with y = exp(-t)
   function automatic occ_type rom_point(input int unsigned i);
      longint unsigned one;
      longint unsigned s;
      longint unsigned term;
      longint unsigned yu;
      longint          y;
      one  = 64'd1 << 30;
      s    = div_u64(longint'(i) << 29, 64'(ENTRIES - 1));
      term = one;
      y    = longint'(one);
      for (int k = 1; k <= 20; k++) begin
         term = div_u64((term * s) >> 30, 64'(k));
         if (k[0] == 1'b1) begin
            y = y - longint'(term);
         end else begin
            y = y + longint'(term);
         end
      end
      yu = (y < 0) ? 64'd0 : longint'(y);
      if (yu > one) begin
         yu = one;
      end
      for (int n = 0; n < 5; n++) begin
         yu = (yu * yu + (64'd1 << 29)) >> 30;
      end
      return 16'(div_u64((yu << 15) + ((one + yu) >> 1), one + yu));
   endfunction

   occ_type tab [ENTRIES];

   // fill the constant table
   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_tab
      localparam occ_type POINT = rom_point(gi);
      assign tab[gi] = POINT;
   end

   // read both interpolation points; hold while stalled
   always_ff @(posedge clock) begin
      if (en) begin
         rd_lo_ff <= tab[rd_idx];
         rd_hi_ff <= tab[rd_idx + IDX_W'(1)];
      end
   end

endmodule

@@ src/fermi_dirac_occupancy.sv @@
// Fermi-Dirac occupancy evaluator: occupancy = 1/(1+exp((energy-fermi_level)/kT)).
// An accepted input word passes stages 1 to 6; stage 6 is the output register.
// Throughput: one word per cycle unless rsp_stall holds it; six stages advance as a whole.
// The whole pipeline holds while a result word waits under rsp_stall.
// Reset (synchronous) empties the pipeline and restores both registers.
// Depends on fdo_pkg and fdo_rom.
module fermi_dirac_occupancy #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  fdo_pkg::q4_12_type     req_energy,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output fdo_pkg::occ_type       rsp_occupancy,
   input  logic                   csr_write,
   input  fdo_pkg::csr_index_type csr_index,
   input  fdo_pkg::csr_data_type  csr_wdata
);
   import fdo_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int P_W   = SAT_BIT + IDX_W;
   localparam logic [IDX_W-1:0] SCALE = IDX_W'(TABLE_ENTRIES - 1);

   // configuration registers
   q4_12_type fermi_level_ff;
   recip_type inv_kt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fermi_level_ff <= FERMI_LEVEL_RESET;
         inv_kt_ff      <= INV_KT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FERMI_LEVEL: fermi_level_ff <= q4_12_type'(csr_wdata);
            CSR_INV_KT:      inv_kt_ff      <= recip_type'(csr_wdata);
            default:         ;
         endcase
      end
   end

   // advance the pipeline unless the output word is held
   logic en;
   logic rsp_valid_ff;
   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // stage 1: energy difference, magnitude and sign
   logic                v1_ff, neg1_ff;
   logic [15:0]         mag1_ff, mag1_in;
   logic signed [16:0]  diff;

   always_comb begin
      diff    = 17'(req_energy) - 17'(fermi_level_ff);
      mag1_in = (diff < 0) ? 16'(-diff) : 16'(diff);
   end

   // stage 2: scaled argument m = |d| * (1/kT), Q.20
   logic         v2_ff, neg2_ff;
   logic [31:0]  m2_ff, m2_in;
   assign m2_in = 32'(mag1_ff) * 32'(inv_kt_ff);

   // stage 3: saturation test and table position p = m * (entries - 1)
   logic            v3_ff, neg3_ff, sat3_ff, sat3_in;
   logic [P_W-1:0]  p3_ff, p3_in;
   assign sat3_in = |m2_ff[31:SAT_BIT];
   assign p3_in   = P_W'(m2_ff[SAT_BIT-1:0]) * P_W'(SCALE);

   // stage 4: table read (registered in the ROM) and interpolation weight
   logic              v4_ff, neg4_ff, sat4_ff;
   logic [15:0]       frac4_ff;
   logic [IDX_W-1:0]  idx3;
   occ_type           t_lo, t_hi;
   assign idx3 = p3_ff[SAT_BIT +: IDX_W];

   fdo_rom #(
      .ENTRIES (TABLE_ENTRIES),
      .IDX_W   (IDX_W)
   ) u_rom (
      .clock    (clock),
      .en       (en),
      .rd_idx   (idx3),
      .rd_lo_ff (t_lo),
      .rd_hi_ff (t_hi)
   );

   // stage 5: weighted table points
   logic         v5_ff, neg5_ff, sat5_ff;
   logic [31:0]  lo5_ff, hi5_ff, lo5_in, hi5_in;
   logic [16:0]  wlo;

   always_comb begin
      wlo    = 17'd65536 - 17'(frac4_ff);
      lo5_in = 32'(33'(t_lo) * 33'(wlo));
      hi5_in = 32'(33'(t_hi) * 33'(frac4_ff));
   end

   // stage 6: round, clamp, mirror for negative argument, saturate
   occ_type      occ_in, rsp_occupancy_ff;
   logic [32:0]  sum6;
   logic [16:0]  g6;

   always_comb begin
      sum6 = 33'(lo5_ff) + 33'(hi5_ff) + 33'd32768;
      g6   = sum6[32:16];
      if (g6 > 17'(OCC_ONE)) begin
         g6 = 17'(OCC_ONE);
      end
      if (sat5_ff) begin
         occ_in = neg5_ff ? OCC_ONE : 16'd0;
      end else if (neg5_ff) begin
         occ_in = OCC_ONE - g6[15:0];
      end else begin
         occ_in = g6[15:0];
      end
   end

   // valid bits
   logic v5_q;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end
   assign v5_q = v5_ff;

   // payload registers
   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff          <= mag1_in;
         neg1_ff          <= diff < 0;
         m2_ff            <= m2_in;
         neg2_ff          <= neg1_ff;
         p3_ff            <= p3_in;
         sat3_ff          <= sat3_in;
         neg3_ff          <= neg2_ff;
         frac4_ff         <= p3_ff[SAT_BIT-1:8];
         sat4_ff          <= sat3_ff;
         neg4_ff          <= neg3_ff;
         lo5_ff           <= lo5_in;
         hi5_ff           <= hi5_in;
         sat5_ff          <= sat4_ff;
         neg5_ff          <= neg4_ff;
         rsp_occupancy_ff <= occ_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

   // occupancy never exceeds one
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_occupancy_ff <= OCC_ONE))
      else $error("occupancy above one");

   // a saturated positive argument gives zero occupancy
   a_sat_zero: assert property (@(posedge clock) disable iff (reset)
      (en && v5_q && sat5_ff && !neg5_ff) |=> (rsp_occupancy_ff == 16'd0))
      else $error("saturated positive argument not zero");

   // a saturated negative argument gives full occupancy
   a_sat_one: assert property (@(posedge clock) disable iff (reset)
      (en && v5_q && sat5_ff && neg5_ff) |=> (rsp_occupancy_ff == OCC_ONE))
      else $error("saturated negative argument not one");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("output valid after reset");

endmodule
